// ===== hdl/acc128_pkg.sv =====
// Shared types and constants for the 128-bit accumulator execute unit.
package acc128_pkg;

    localparam int unsigned SIGN_BIT = 127;

    localparam logic [4:0] OP_LDA   = 5'd0;
    localparam logic [4:0] OP_LDB   = 5'd1;
    localparam logic [4:0] OP_ADD   = 5'd2;
    localparam logic [4:0] OP_SUB   = 5'd3;
    localparam logic [4:0] OP_MUL   = 5'd4;
    localparam logic [4:0] OP_DIV   = 5'd5;
    localparam logic [4:0] OP_INCA  = 5'd6;
    localparam logic [4:0] OP_INCB  = 5'd7;
    localparam logic [4:0] OP_DECA  = 5'd8;
    localparam logic [4:0] OP_DECB  = 5'd9;
    localparam logic [4:0] OP_AND   = 5'd10;
    localparam logic [4:0] OP_OR    = 5'd11;
    localparam logic [4:0] OP_XOR   = 5'd12;
    localparam logic [4:0] OP_NOTA  = 5'd13;
    localparam logic [4:0] OP_NOTB  = 5'd14;
    localparam logic [4:0] OP_STORE = 5'd15;
    localparam logic [4:0] OP_LOAD  = 5'd16;
    localparam logic [4:0] OP_JMP   = 5'd17;
    localparam logic [4:0] OP_JZ    = 5'd18;
    localparam logic [4:0] OP_JNZ   = 5'd19;

    typedef struct packed {
        logic [4:0]  operation;
        logic [63:0] value_low;
        logic [63:0] value_high;
        logic [63:0] address;
    } t_in;

    typedef struct packed {
        logic [63:0] acc_low;
        logic [63:0] acc_high;
        logic [63:0] a_low;
        logic [63:0] a_high;
        logic [63:0] b_low;
        logic [63:0] b_high;
        logic        zero_flag;
        logic        negative_flag;
        logic [63:0] program_counter;
        logic [63:0] cycle_count;
    } t_out;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_req;

endpackage

// ===== hdl/accumulator_cpu_128bit_execute_unit.sv =====
// Top level: 128-bit accumulator machine executing one instruction per transaction.
//
//  channel | direction | payload            | handshake
//  in      | input     | acc128_pkg::t_in   | i_in_valid / o_in_stall
//  out     | output    | acc128_pkg::t_out  | o_out_valid / i_out_stall
//
// Each accepted instruction is registered and executed in the EXEC state, which writes
// the output register, and the unit then returns to idle before it takes the next one.
// Mul and div first pass through the MD state: 128 steps of the bit-serial unit,
// then its done flag, then write back in EXEC and return to idle.
// After reset the data memory is cleared one word per cycle, with input stalled.
// A result waits in the output register while the next instruction is taken; the
// unit holds its finished result in EXEC while that register is full and the output
// is stalled.
module accumulator_cpu_128bit_execute_unit #(
    parameter int unsigned RAM_DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  acc128_pkg::t_in  i_in,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output acc128_pkg::t_out o_out,
    input  logic             i_out_stall
);
    localparam int unsigned AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_MD    = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr;
    logic [4:0]    r_op;
    logic [127:0]  r_imm;
    logic [63:0]   r_addr;
    logic          r_in_range;
    logic [127:0]  r_a, r_b, r_acc, n_a, n_b, n_acc;
    logic          r_z, r_n, n_z, n_n;
    logic [63:0]   r_pc, r_cyc, n_pc;
    logic          r_out_valid;
    acc128_pkg::t_out r_out;

    logic           accept, in_range, out_free, md_done, flag_set;
    logic [127:0]   md_res, ram_rdata, flag_val;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [127:0]   ram_wdata;
    acc128_pkg::t_md_req md_req;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign in_range = (i_in.address < 64'(RAM_DEPTH));
    assign out_free = !r_out_valid || !i_out_stall;

    assign md_req.start  = accept && (i_in.operation == acc128_pkg::OP_MUL ||
                                      i_in.operation == acc128_pkg::OP_DIV);
    assign md_req.is_div = (i_in.operation == acc128_pkg::OP_DIV);

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else begin
            ram_we    = accept && in_range && (i_in.operation == acc128_pkg::OP_STORE);
            ram_waddr = i_in.address[AW-1:0];
            ram_wdata = r_acc;
        end
    end

    acc128_ram #(.WIDTH(128), .DEPTH(RAM_DEPTH)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (i_in.address[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    acc128_muldiv u_md (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (md_req),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_done   (md_done),
        .o_result (md_res)
    );

    always_comb begin
        n_a      = r_a;
        n_b      = r_b;
        n_acc    = r_acc;
        n_pc     = r_pc + 64'd1;
        flag_set = 1'b1;
        unique case (r_op)
            acc128_pkg::OP_LDA:   begin n_a = r_imm; flag_set = 1'b0; end
            acc128_pkg::OP_LDB:   begin n_b = r_imm; flag_set = 1'b0; end
            acc128_pkg::OP_ADD:   n_acc = r_a + r_b;
            acc128_pkg::OP_SUB:   n_acc = r_a - r_b;
            acc128_pkg::OP_MUL:   n_acc = md_res;
            acc128_pkg::OP_DIV:   n_acc = md_res;
            acc128_pkg::OP_INCA:  n_a = r_a + 128'd1;
            acc128_pkg::OP_INCB:  n_b = r_b + 128'd1;
            acc128_pkg::OP_DECA:  n_a = r_a - 128'd1;
            acc128_pkg::OP_DECB:  n_b = r_b - 128'd1;
            acc128_pkg::OP_AND:   n_acc = r_a & r_b;
            acc128_pkg::OP_OR:    n_acc = r_a | r_b;
            acc128_pkg::OP_XOR:   n_acc = r_a ^ r_b;
            acc128_pkg::OP_NOTA:  n_acc = ~r_a;
            acc128_pkg::OP_NOTB:  n_acc = ~r_b;
            acc128_pkg::OP_STORE: flag_set = 1'b0;
            acc128_pkg::OP_LOAD:  n_acc = r_in_range ? ram_rdata : r_acc;
            acc128_pkg::OP_JMP:   begin n_pc = r_addr; flag_set = 1'b0; end
            acc128_pkg::OP_JZ:    begin
                if (r_z) n_pc = r_addr;
                flag_set = 1'b0;
            end
            acc128_pkg::OP_JNZ:   begin
                if (!r_z) n_pc = r_addr;
                flag_set = 1'b0;
            end
            default:              flag_set = 1'b0;
        endcase
        // Increment and decrement take their flags from the register they change.
        if (r_op == acc128_pkg::OP_INCA || r_op == acc128_pkg::OP_DECA) begin
            flag_val = n_a;
        end else if (r_op == acc128_pkg::OP_INCB || r_op == acc128_pkg::OP_DECB) begin
            flag_val = n_b;
        end else begin
            flag_val = n_acc;
        end
        n_z = flag_set ? (flag_val == 128'd0) : r_z;
        n_n = flag_set ? flag_val[acc128_pkg::SIGN_BIT] : r_n;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == AW'(RAM_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = md_req.start ? S_MD : S_EXEC;
            S_MD:    if (md_done) n_state = S_EXEC;
            S_EXEC:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_a   <= '0;
            r_b   <= '0;
            r_acc <= '0;
            r_z   <= 1'b0;
            r_n   <= 1'b0;
            r_pc  <= '0;
            r_cyc <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (accept) begin
                r_op       <= i_in.operation;
                r_imm      <= {i_in.value_high, i_in.value_low};
                r_addr     <= i_in.address;
                r_in_range <= in_range;
            end
            if (r_state == S_EXEC && out_free) begin
                r_a   <= n_a;
                r_b   <= n_b;
                r_acc <= n_acc;
                r_z   <= n_z;
                r_n   <= n_n;
                r_pc  <= n_pc;
                r_cyc <= r_cyc + 64'd1;
                r_out_valid <= 1'b1;
                r_out <= '{acc_low: n_acc[63:0], acc_high: n_acc[127:64],
                           a_low: n_a[63:0], a_high: n_a[127:64],
                           b_low: n_b[63:0], b_high: n_b[127:64],
                           zero_flag: n_z, negative_flag: n_n,
                           program_counter: n_pc, cycle_count: r_cyc + 64'd1};
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

// ===== hdl/acc128_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module acc128_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/acc128_muldiv.sv =====
// Bit-serial 128-bit multiplier (low half) and restoring divider.
module acc128_muldiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  acc128_pkg::t_md_req i_req,
    input  logic [127:0]        i_a,
    input  logic [127:0]        i_b,
    output logic                o_done,
    output logic [127:0]        o_result
);
    logic [127:0] r_x, n_x;
    logic [127:0] r_y, n_y;
    logic [127:0] r_p, n_p;
    logic [6:0]   r_cnt;
    logic         r_busy, r_div, r_dz, r_done;
    logic [128:0] rem_sh;
    logic [128:0] rem_sub;

    always_comb begin
        rem_sh  = {r_p, r_x[127]};
        rem_sub = rem_sh - {1'b0, r_y};
        n_x = r_x;
        n_y = r_y;
        n_p = r_p;
        if (r_div) begin
            // A borrow out of the 129-bit subtract means the divisor did not fit.
            if (!rem_sub[128] || rem_sh[128]) begin
                n_p = rem_sub[127:0];
                n_x = {r_x[126:0], 1'b1};
            end else begin
                n_p = rem_sh[127:0];
                n_x = {r_x[126:0], 1'b0};
            end
        end else begin
            if (r_y[0]) begin
                n_p = r_p + r_x;
            end
            n_x = {r_x[126:0], 1'b0};
            n_y = {1'b0, r_y[127:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_div  <= i_req.is_div;
                r_dz   <= (i_b == 128'd0);
                r_x    <= i_a;
                r_y    <= i_b;
                r_p    <= '0;
            end else if (r_busy) begin
                r_x   <= n_x;
                r_y   <= n_y;
                r_p   <= n_p;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd127) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_div ? (r_dz ? 128'd0 : r_x) : r_p;
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the 128-bit accumulator execute unit.
`timescale 1ns / 1ps

module tb;
    localparam int unsigned MEM_WORDS = 1024;
    localparam int unsigned MEM_AW = $clog2(MEM_WORDS);
    localparam int HOLD_OFF_LEN = 400;
    localparam longint unsigned CYCLE_LIMIT = 64'd3_000_000;

    // Predicts the architectural state after each instruction and checks results in order.
    class exec_scoreboard;
        logic [127:0] a_q, b_q, acc_q;
        logic         zf_q, nf_q;
        logic [63:0]  pc_q, count_q;
        logic [127:0] mem_q [MEM_WORDS];
        acc128_pkg::t_out pending_q [$];
        int           mismatch_cnt;
        int           checked_cnt;

        function new();
            a_q = '0; b_q = '0; acc_q = '0; zf_q = 0; nf_q = 0;
            pc_q = '0; count_q = '0;
            foreach (mem_q[i]) mem_q[i] = '0;
            mismatch_cnt = 0;
            checked_cnt = 0;
        endfunction

        function void set_flags(logic [127:0] v);
            zf_q = (v == '0);
            nf_q = v[acc128_pkg::SIGN_BIT];
        endfunction

        function logic [127:0] divide(logic [127:0] n, logic [127:0] d);
            logic [128:0] rem;
            logic [127:0] q;
            rem = '0;
            q = '0;
            if (d == '0) return '0;
            for (int i = 127; i >= 0; i--) begin
                rem = {rem[127:0], n[i]};
                if (rem >= {1'b0, d}) begin
                    rem = rem - {1'b0, d};
                    q[i] = 1'b1;
                end
            end
            return q;
        endfunction

        function void note_instruction(acc128_pkg::t_in it);
            logic jumped;
            acc128_pkg::t_out r;
            jumped = 0;
            case (it.operation)
                acc128_pkg::OP_LDA: a_q = {it.value_high, it.value_low};
                acc128_pkg::OP_LDB: b_q = {it.value_high, it.value_low};
                acc128_pkg::OP_ADD: begin acc_q = a_q + b_q; set_flags(acc_q); end
                acc128_pkg::OP_SUB: begin acc_q = a_q - b_q; set_flags(acc_q); end
                acc128_pkg::OP_MUL: begin acc_q = a_q * b_q; set_flags(acc_q); end
                acc128_pkg::OP_DIV: begin acc_q = divide(a_q, b_q); set_flags(acc_q); end
                acc128_pkg::OP_INCA: begin a_q = a_q + 128'd1; set_flags(a_q); end
                acc128_pkg::OP_INCB: begin b_q = b_q + 128'd1; set_flags(b_q); end
                acc128_pkg::OP_DECA: begin a_q = a_q - 128'd1; set_flags(a_q); end
                acc128_pkg::OP_DECB: begin b_q = b_q - 128'd1; set_flags(b_q); end
                acc128_pkg::OP_AND: begin acc_q = a_q & b_q; set_flags(acc_q); end
                acc128_pkg::OP_OR: begin acc_q = a_q | b_q; set_flags(acc_q); end
                acc128_pkg::OP_XOR: begin acc_q = a_q ^ b_q; set_flags(acc_q); end
                acc128_pkg::OP_NOTA: begin acc_q = ~a_q; set_flags(acc_q); end
                acc128_pkg::OP_NOTB: begin acc_q = ~b_q; set_flags(acc_q); end
                acc128_pkg::OP_STORE:
                    if (it.address < MEM_WORDS) mem_q[it.address[MEM_AW-1:0]] = acc_q;
                acc128_pkg::OP_LOAD: begin
                    if (it.address < MEM_WORDS) acc_q = mem_q[it.address[MEM_AW-1:0]];
                    set_flags(acc_q);
                end
                acc128_pkg::OP_JMP: begin pc_q = it.address; jumped = 1; end
                acc128_pkg::OP_JZ: if (zf_q) begin pc_q = it.address; jumped = 1; end
                acc128_pkg::OP_JNZ: if (!zf_q) begin pc_q = it.address; jumped = 1; end
                default: ;
            endcase
            if (!jumped) pc_q++;
            count_q++;
            r.acc_low = acc_q[63:0];
            r.acc_high = acc_q[127:64];
            r.a_low = a_q[63:0];
            r.a_high = a_q[127:64];
            r.b_low = b_q[63:0];
            r.b_high = b_q[127:64];
            r.zero_flag = zf_q;
            r.negative_flag = nf_q;
            r.program_counter = pc_q;
            r.cycle_count = count_q;
            pending_q.push_back(r);
        endfunction

        function void check_state(acc128_pkg::t_out got);
            acc128_pkg::t_out exp;
            if (pending_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result transaction: %h", got);
                return;
            end
            exp = pending_q.pop_front();
            checked_cnt++;
            if (got !== exp) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("mismatch on result %0d:", checked_cnt);
                    $display("  expected acc=%h_%h a=%h_%h b=%h_%h z=%b n=%b pc=%h cnt=%h",
                             exp.acc_high, exp.acc_low, exp.a_high, exp.a_low, exp.b_high,
                             exp.b_low, exp.zero_flag, exp.negative_flag,
                             exp.program_counter, exp.cycle_count);
                    $display("  actual   acc=%h_%h a=%h_%h b=%h_%h z=%b n=%b pc=%h cnt=%h",
                             got.acc_high, got.acc_low, got.a_high, got.a_low, got.b_high,
                             got.b_low, got.zero_flag, got.negative_flag,
                             got.program_counter, got.cycle_count);
                end
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    acc128_pkg::t_in  i_in = '0;
    logic o_in_stall;
    logic o_out_valid;
    acc128_pkg::t_out o_out;
    logic i_out_stall = 0;

    exec_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_off_req = 0;
    bit hold_off_taken = 0;
    int hold_off_cycles = 0;
    longint unsigned cycle_cnt = 0;

    accumulator_cpu_128bit_execute_unit #(.RAM_DEPTH(MEM_WORDS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .i_in(i_in),
        .o_in_stall(o_in_stall), .o_out_valid(o_out_valid), .o_out(o_out),
        .i_out_stall(i_out_stall)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", sb.pending_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: check each accepted transaction, stall randomly or for a long hold-off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_state(o_out);
        if (hold_off_req && !hold_off_taken) begin
            hold_off_taken <= 1;
            hold_off_cycles <= HOLD_OFF_LEN - 1;
            i_out_stall <= 1;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_stall <= 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Operand values biased toward edges so carries, zero and sign bits all get hit.
    function automatic logic [63:0] edge64();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'd1;
            default: return rand64();
        endcase
    endfunction

    task automatic send(logic [4:0] op, logic [63:0] lo, logic [63:0] hi, logic [63:0] addr);
        acc128_pkg::t_in it;
        it.operation = op;
        it.value_low = lo;
        it.value_high = hi;
        it.address = addr;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_instruction(it);
    endtask

    task automatic send_random();
        logic [63:0] addr;
        logic [4:0]  op;
        case ($urandom_range(3))
            0: addr = 64'($urandom_range(MEM_WORDS - 1));
            1: addr = 64'($urandom_range(15));
            2: addr = 64'(MEM_WORDS + $urandom_range(3));
            default: addr = rand64();
        endcase
        // Mostly valid opcodes; a few undefined ones exercise the no-op path.
        op = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 20)) : 5'($urandom_range(19));
        // Mul and div are slow, so keep them to a fraction of the traffic.
        if ((op == acc128_pkg::OP_MUL || op == acc128_pkg::OP_DIV) && $urandom_range(2) != 0)
            op = acc128_pkg::OP_ADD;
        send(op, edge64(), edge64(), addr);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending_q.size() != 0 || (hold_off_req && !hold_off_taken) ||
               hold_off_cycles != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, every operation, zero divisor, out-of-range memory, jumps.
        send(acc128_pkg::OP_LDA, '1, '1, 0);
        send(acc128_pkg::OP_LDB, 64'd1, '0, 0);
        send(acc128_pkg::OP_ADD, 0, 0, 0);
        send(acc128_pkg::OP_SUB, 0, 0, 0);
        send(acc128_pkg::OP_MUL, 0, 0, 0);
        send(acc128_pkg::OP_DIV, 0, 0, 0);
        send(acc128_pkg::OP_STORE, 0, 0, 64'(MEM_WORDS - 1));
        send(acc128_pkg::OP_STORE, 0, 0, 64'(MEM_WORDS));
        send(acc128_pkg::OP_LDB, '0, '0, 0);
        send(acc128_pkg::OP_DIV, 0, 0, 0);
        send(acc128_pkg::OP_JZ, 0, 0, '1);
        send(acc128_pkg::OP_JNZ, 0, 0, 64'd5);
        send(acc128_pkg::OP_LOAD, 0, 0, 64'(MEM_WORDS - 1));
        send(acc128_pkg::OP_LOAD, 0, 0, '1);
        send(acc128_pkg::OP_INCA, 0, 0, 0);
        send(acc128_pkg::OP_DECB, 0, 0, 0);
        send(acc128_pkg::OP_INCB, 0, 0, 0);
        send(acc128_pkg::OP_DECA, 0, 0, 0);
        send(acc128_pkg::OP_AND, 0, 0, 0);
        send(acc128_pkg::OP_OR, 0, 0, 0);
        send(acc128_pkg::OP_XOR, 0, 0, 0);
        send(acc128_pkg::OP_NOTA, 0, 0, 0);
        send(acc128_pkg::OP_NOTB, 0, 0, 0);
        send(acc128_pkg::OP_JMP, 0, 0, 64'h8000_0000_0000_0000);
        send(5'd31, 0, 0, 0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 6; stall_pct = 6; end
            endcase
            if (phase == 0) hold_off_req = 1;
            for (int n = 0; n < 300; n++) send_random();
            drain();
        end

        repeat (200) @(posedge i_clk);
        $display("Ran %0d instructions over all 20 operations plus undefined codes,",
                 sb.checked_cnt);
        $display("with random idling, output stalls and a long output hold-off.");
        if (sb.mismatch_cnt == 0 && sb.pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", sb.mismatch_cnt);
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/acc128_pkg.sv
hdl/acc128_ram.sv
hdl/acc128_muldiv.sv
hdl/accumulator_cpu_128bit_execute_unit.sv
verif/tb.sv
